### src/oven_countdown_timer_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Oven countdown timer controller: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef OVEN_COUNTDOWN_TIMER_CONTROLLER_TOP_DEFINES_SVH
`define OVEN_COUNTDOWN_TIMER_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define OCTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("octc assertion failed");

// next-cycle implication
`define OCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("octc assertion failed");

`endif

### src/octc_pkg.sv
// ----------------------------------------------------------------------------
// Oven countdown timer controller package
// Types, codes, reset values and small helper functions.
// ----------------------------------------------------------------------------
package octc_pkg;

  localparam int unsigned TEMP_WIDTH_DEF = 12;
  localparam int unsigned TEMP_LIMIT_W   = 12;
  localparam int unsigned TICKS_W        = 10;
  localparam int unsigned MIN_W          = 7;
  localparam int unsigned LP_W           = 3;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 12;
  localparam int unsigned BAR_W          = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_WRAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER_LEVEL     = 3'd4;

  // reset values
  localparam logic [TEMP_LIMIT_W-1:0] TEMP_LIMIT_RST       = 12'd200;
  localparam logic [TICKS_W-1:0]      TICKS_PER_MINUTE_RST = 10'd600;
  localparam logic [MIN_W-1:0]        MINUTE_WRAP_RST      = 7'd120;
  localparam logic [MIN_W-1:0]        LONG_PRESS_STEP_RST  = 7'd10;
  localparam logic                    HEATER_LEVEL_RST     = 1'b1;

  // button and switch codes
  localparam logic [1:0] BTN_OFF   = 2'd0;
  localparam logic [1:0] BTN_PRESS = 2'd1;
  localparam logic [1:0] BTN_LONG  = 2'd2;
  localparam logic [1:0] SW_OFF    = 2'd0;
  localparam logic [1:0] SW_ON     = 2'd1;

  // mode codes as seen on the result beat
  localparam logic [1:0] MODE_CODE_ADJUST   = 2'd0;
  localparam logic [1:0] MODE_CODE_HEATING  = 2'd1;
  localparam logic [1:0] MODE_CODE_FINISHED = 2'd2;
  localparam logic [1:0] MODE_CODE_ERROR    = 2'd3;

  // seconds bar and refresh constants
  localparam logic [TICKS_W-1:0] BAR_FULL_TICKS = 10'd600;
  localparam logic [BAR_W-1:0]   BAR_MAX        = 4'd12;
  localparam logic [5:0]         REFRESH_PERIOD = 6'd50;
  localparam logic [5:0]         DIV50_MUL      = 6'd41;
  localparam int unsigned        DIV50_SHIFT    = 11;

  typedef enum logic [3:0] {
    MODE_ADJUST   = 4'b0001,
    MODE_HEATING  = 4'b0010,
    MODE_FINISHED = 4'b0100,
    MODE_ERROR    = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [TEMP_LIMIT_W-1:0] temp_limit;
    logic [TICKS_W-1:0]      ticks_per_minute;
    logic [MIN_W-1:0]        minute_wrap;
    logic [MIN_W-1:0]        long_press_step;
    logic                    heater_active_level;
  } cfg_t;

  function automatic logic [1:0] mode_code(input mode_e m);
    logic [1:0] c;
    case (m)
      MODE_ADJUST:   c = MODE_CODE_ADJUST;
      MODE_HEATING:  c = MODE_CODE_HEATING;
      MODE_FINISHED: c = MODE_CODE_FINISHED;
      MODE_ERROR:    c = MODE_CODE_ERROR;
      default:       c = MODE_CODE_ADJUST;
    endcase
    return c;
  endfunction

  function automatic logic [MIN_W-1:0] add_minutes(input logic [MIN_W-1:0] cur,
                                                   input logic [MIN_W-1:0] amt,
                                                   input logic [MIN_W-1:0] wrap);
    logic [MIN_W:0] sum;
    sum = {1'b0, cur} + {1'b0, amt};
    if (sum >= {1'b0, wrap}) begin
      return '0;
    end
    return sum[MIN_W-1:0];
  endfunction

  // exact quotient by 50 for any 10-bit value
  function automatic logic [4:0] div50(input logic [TICKS_W-1:0] v);
    logic [15:0] p;
    p = {6'b0, v} * {10'b0, DIV50_MUL};
    return p[15:DIV50_SHIFT];
  endfunction

  function automatic logic mult_of_50(input logic [TICKS_W-1:0] v);
    logic [10:0] prod;
    prod = {6'b0, div50(v)} * {5'b0, REFRESH_PERIOD};
    return prod[TICKS_W-1:0] == v;
  endfunction

  function automatic logic [BAR_W-1:0] bar_count(input logic [TICKS_W-1:0] v);
    logic [4:0] q;
    q = div50(v);
    if (v >= BAR_FULL_TICKS) begin
      return BAR_MAX;
    end
    return q[BAR_W-1:0];
  endfunction

endpackage

### src/octc_if.sv
// ----------------------------------------------------------------------------
// Oven countdown timer controller channels
// Valid/ready interfaces for the tick input and the result output.
// ----------------------------------------------------------------------------
interface octc_in_if #(
  parameter int unsigned TEMP_WIDTH = octc_pkg::TEMP_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [TEMP_WIDTH-1:0] temperature;
  logic [1:0]            push_button;
  logic [1:0]            switch_state;

  modport source (output valid, temperature, push_button, switch_state, input ready);
  modport sink (input valid, temperature, push_button, switch_state, output ready);
endinterface

interface octc_out_if;
  logic       valid;
  logic       ready;
  logic       heater_drive;
  logic [1:0] mode;
  logic [6:0] minutes;
  logic       display_refresh;
  logic [3:0] bar_count;

  modport source (output valid, heater_drive, mode, minutes, display_refresh, bar_count,
                  input ready);
  modport sink (input valid, heater_drive, mode, minutes, display_refresh, bar_count,
                output ready);
endinterface

### src/octc_cfg.sv
// ----------------------------------------------------------------------------
// Oven countdown timer controller configuration registers
// Write-only register file, indexed by the configuration port.
// ----------------------------------------------------------------------------
module octc_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [octc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [octc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output octc_pkg::cfg_t                       cfg_o
);

  octc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        octc_pkg::CFG_TEMP_LIMIT:
          cfg_d.temp_limit = cfg_wdata_i[octc_pkg::TEMP_LIMIT_W-1:0];
        octc_pkg::CFG_TICKS_PER_MINUTE:
          cfg_d.ticks_per_minute = cfg_wdata_i[octc_pkg::TICKS_W-1:0];
        octc_pkg::CFG_MINUTE_WRAP:
          cfg_d.minute_wrap = cfg_wdata_i[octc_pkg::MIN_W-1:0];
        octc_pkg::CFG_LONG_PRESS_STEP:
          cfg_d.long_press_step = cfg_wdata_i[octc_pkg::MIN_W-1:0];
        octc_pkg::CFG_HEATER_LEVEL:
          cfg_d.heater_active_level = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_limit          <= octc_pkg::TEMP_LIMIT_RST;
      cfg_q.ticks_per_minute    <= octc_pkg::TICKS_PER_MINUTE_RST;
      cfg_q.minute_wrap         <= octc_pkg::MINUTE_WRAP_RST;
      cfg_q.long_press_step     <= octc_pkg::LONG_PRESS_STEP_RST;
      cfg_q.heater_active_level <= octc_pkg::HEATER_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/octc_core.sv
// ----------------------------------------------------------------------------
// Oven countdown timer controller core
// Input register, per-tick state update and result register.
// ----------------------------------------------------------------------------
module octc_core #(
  parameter int unsigned TEMP_WIDTH = octc_pkg::TEMP_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  octc_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [TEMP_WIDTH-1:0]             temperature_i,
  input  logic [1:0]                        push_button_i,
  input  logic [1:0]                        switch_state_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              heater_drive_o,
  output logic [1:0]                        mode_o,
  output logic [octc_pkg::MIN_W-1:0]        minutes_o,
  output logic                              display_refresh_o,
  output logic [octc_pkg::BAR_W-1:0]        bar_count_o
);

  localparam int unsigned CMP_W =
    (TEMP_WIDTH > octc_pkg::TEMP_LIMIT_W) ? TEMP_WIDTH : octc_pkg::TEMP_LIMIT_W;

  // input stage
  logic                  in_v_q;
  logic [TEMP_WIDTH-1:0] temp_q;
  logic [1:0]            btn_q;
  logic [1:0]            sw_q;

  // controller state
  octc_pkg::mode_e                mode_q, mode_d;
  logic [octc_pkg::MIN_W-1:0]     mc_q, mc_d;
  logic [octc_pkg::TICKS_W-1:0]   cd_q, cd_d;
  logic [1:0]                     last_q;
  logic [octc_pkg::LP_W-1:0]      lpt_q, lpt_d;

  // result stage
  logic                           out_v_q;
  logic                           heater_q, heater_d;
  logic [1:0]                     mode_code_q;
  logic [octc_pkg::MIN_W-1:0]     min_q;
  logic                           refresh_q, refresh_d;
  logic [octc_pkg::BAR_W-1:0]     bar_q, bar_d;

  logic advance;
  logic over_temp;

  assign advance    = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || advance;
  assign over_temp  = CMP_W'(temp_q) > CMP_W'(cfg_i.temp_limit);

  always_comb begin
    mode_d    = mode_q;
    mc_d      = mc_q;
    cd_d      = cd_q;
    lpt_d     = lpt_q;
    refresh_d = 1'b0;
    if (over_temp) begin
      mode_d    = octc_pkg::MODE_ERROR;
      mc_d      = '0;
      cd_d      = cfg_i.ticks_per_minute;
      refresh_d = 1'b1;
    end else begin
      case (mode_q)
        octc_pkg::MODE_ADJUST: begin
          if (btn_q == octc_pkg::BTN_PRESS && last_q == octc_pkg::BTN_OFF) begin
            mc_d      = octc_pkg::add_minutes(mc_q, 7'd1, cfg_i.minute_wrap);
            refresh_d = 1'b1;
          end else if (btn_q == octc_pkg::BTN_LONG) begin
            lpt_d = lpt_q + 3'd1;
            if (lpt_d == '0) begin
              mc_d      = octc_pkg::add_minutes(mc_q, cfg_i.long_press_step,
                                                cfg_i.minute_wrap);
              refresh_d = 1'b1;
            end
          end
          if (sw_q == octc_pkg::SW_ON && mc_d != '0) begin
            mode_d    = octc_pkg::MODE_HEATING;
            refresh_d = 1'b1;
          end
        end
        octc_pkg::MODE_HEATING: begin
          if (sw_q != octc_pkg::SW_OFF) begin
            if (cd_q <= 10'd1) begin
              cd_d = cfg_i.ticks_per_minute;
              if (mc_q <= 7'd1) begin
                mc_d   = '0;
                mode_d = octc_pkg::MODE_FINISHED;
              end else begin
                mc_d = mc_q - 7'd1;
              end
              refresh_d = 1'b1;
            end else begin
              cd_d = cd_q - 10'd1;
              if (octc_pkg::mult_of_50(cd_d)) begin
                refresh_d = 1'b1;
              end
            end
          end else begin
            mode_d    = octc_pkg::MODE_ADJUST;
            refresh_d = 1'b1;
          end
        end
        default: begin
          if (sw_q == octc_pkg::SW_OFF) begin
            mode_d    = octc_pkg::MODE_ADJUST;
            refresh_d = 1'b1;
          end
        end
      endcase
    end

    if (mode_d == octc_pkg::MODE_HEATING) begin
      bar_d    = octc_pkg::bar_count(cd_d);
      heater_d = cfg_i.heater_active_level;
    end else begin
      bar_d    = '0;
      heater_d = !cfg_i.heater_active_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      mode_q  <= octc_pkg::MODE_ADJUST;
      mc_q    <= '0;
      cd_q    <= octc_pkg::TICKS_PER_MINUTE_RST;
      last_q  <= octc_pkg::BTN_OFF;
      lpt_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (advance) begin
        out_v_q <= 1'b1;
        mode_q  <= mode_d;
        mc_q    <= mc_d;
        cd_q    <= cd_d;
        last_q  <= btn_q;
        lpt_q   <= lpt_d;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      temp_q <= temperature_i;
      btn_q  <= push_button_i;
      sw_q   <= switch_state_i;
    end
    if (advance) begin
      heater_q    <= heater_d;
      mode_code_q <= octc_pkg::mode_code(mode_d);
      min_q       <= mc_d;
      refresh_q   <= refresh_d;
      bar_q       <= bar_d;
    end
  end

  assign out_valid_o       = out_v_q;
  assign heater_drive_o    = heater_q;
  assign mode_o            = mode_code_q;
  assign minutes_o         = min_q;
  assign display_refresh_o = refresh_q;
  assign bar_count_o       = bar_q;

endmodule

### src/oven_countdown_timer_controller_top.sv
// ----------------------------------------------------------------------------
// Oven countdown timer controller
// Per-tick timer, button and temperature supervision for an oven heater.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one tick beat: temperature sample, push button, switch.
//   out_if returns exactly one result beat per tick: heater pin level, mode,
//   minutes, display refresh flag and seconds bar count.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the five settings; write only while
//   no tick is in flight.
// Path: a tick beat is taken into the input register, then its result is
//   written into the result register.
// Throughput: one tick per cycle while out_if.ready stays high; the state
//   update loops through the core's next-state logic with no other register.
// Reset: mode adjust, minutes 0, countdown 600, settings at defaults, both
//   channels empty.
// Stall: while out_if.ready is low the result holds; one more tick may sit in
//   the input register, after which in_if.ready drops.
// ----------------------------------------------------------------------------
module oven_countdown_timer_controller_top #(
  parameter int unsigned TEMP_WIDTH = octc_pkg::TEMP_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  octc_in_if.sink                           in_if,
  octc_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [octc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [octc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  octc_pkg::cfg_t cfg;

  octc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  octc_core #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_if.valid),
    .in_ready_o        (in_if.ready),
    .temperature_i     (in_if.temperature),
    .push_button_i     (in_if.push_button),
    .switch_state_i    (in_if.switch_state),
    .out_valid_o       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .heater_drive_o    (out_if.heater_drive),
    .mode_o            (out_if.mode),
    .minutes_o         (out_if.minutes),
    .display_refresh_o (out_if.display_refresh),
    .bar_count_o       (out_if.bar_count)
  );

endmodule

### src/octc_checker.sv
// ----------------------------------------------------------------------------
// Oven countdown timer controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "oven_countdown_timer_controller_top_defines.svh"

module octc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_mode_i,
  input logic [6:0] out_minutes_i,
  input logic [3:0] out_bar_count_i
);

  `OCTC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_mode_i) && $stable(out_minutes_i) && $stable(out_bar_count_i))
  `OCTC_ASSERT_IMPLY(a_bar_idle, clk_i, rst_ni, out_valid_i && (out_mode_i != octc_pkg::MODE_CODE_HEATING), out_bar_count_i == '0)
  `OCTC_ASSERT_IMPLY(a_bar_range, clk_i, rst_ni, out_valid_i, out_bar_count_i <= octc_pkg::BAR_MAX)
  `OCTC_ASSERT_IMPLY(a_done_zero, clk_i, rst_ni, out_valid_i && (out_mode_i == octc_pkg::MODE_CODE_FINISHED || out_mode_i == octc_pkg::MODE_CODE_ERROR), out_minutes_i == '0)

endmodule

bind oven_countdown_timer_controller_top octc_checker u_octc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_mode_i      (out_if.mode),
  .out_minutes_i   (out_if.minutes),
  .out_bar_count_i (out_if.bar_count)
);

### tb/tb_oven_countdown_timer_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oven countdown timer controller testbench
// Sends tick beats (temperature, button, switch) through the input channel and
// checks every result beat against a cycle-free model of the timer kept here.
// Covers key handling, countdown, over-temperature, the setting registers at
// their extremes, random cooking sequences with idle gaps on both sides, and
// a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_oven_countdown_timer_controller_top;
  import octc_pkg::*;

  localparam int unsigned TEMP_W = TEMP_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic             heater_drive;
    logic [1:0]       mode;
    logic [MIN_W-1:0] minutes;
    logic             display_refresh;
    logic [BAR_W-1:0] bar_count;
  } oven_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  octc_in_if #(.TEMP_WIDTH(TEMP_W)) tick_ch ();
  octc_out_if result_ch ();

  oven_countdown_timer_controller_top #(
    .TEMP_WIDTH(TEMP_W)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (tick_ch),
    .out_if      (result_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // timer model state and settings
  cfg_t               timer_cfg;
  logic [1:0]         oven_mode;
  logic [MIN_W-1:0]   set_minutes;
  logic [TICKS_W-1:0] tick_left;
  logic [1:0]         prev_button;
  logic [LP_W-1:0]    hold_ticks;

  oven_result_t expected_results[$];
  int fail_count;
  int ticks_sent;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [MIN_W-1:0] bump_minutes(input logic [MIN_W-1:0] amount);
    logic [MIN_W:0] sum;
    sum = {1'b0, set_minutes} + {1'b0, amount};
    if (sum >= {1'b0, timer_cfg.minute_wrap}) begin
      return '0;
    end
    return sum[MIN_W-1:0];
  endfunction

  function automatic oven_result_t predict_tick(input logic [TEMP_W-1:0] temp,
                                                input logic [1:0] btn,
                                                input logic [1:0] sw);
    oven_result_t r;
    logic [6:0] secs;
    r = '0;
    if (temp > timer_cfg.temp_limit) begin
      set_minutes = '0;
      tick_left = timer_cfg.ticks_per_minute;
      oven_mode = MODE_CODE_ERROR;
      r.display_refresh = 1'b1;
    end else if (oven_mode == MODE_CODE_ADJUST) begin
      if (btn == BTN_PRESS && prev_button == BTN_OFF) begin
        set_minutes = bump_minutes(7'd1);
        r.display_refresh = 1'b1;
      end else if (btn == BTN_LONG) begin
        hold_ticks = hold_ticks + 1'b1;
        if (hold_ticks == '0) begin
          set_minutes = bump_minutes(timer_cfg.long_press_step);
          r.display_refresh = 1'b1;
        end
      end
      if (sw == SW_ON && set_minutes != '0) begin
        oven_mode = MODE_CODE_HEATING;
        r.display_refresh = 1'b1;
      end
    end else if (oven_mode == MODE_CODE_HEATING) begin
      if (sw != SW_OFF) begin
        if (tick_left <= 10'd1) begin
          tick_left = timer_cfg.ticks_per_minute;
          if (set_minutes <= 7'd1) begin
            set_minutes = '0;
            oven_mode = MODE_CODE_FINISHED;
          end else begin
            set_minutes = set_minutes - 1'b1;
          end
          r.display_refresh = 1'b1;
        end else begin
          tick_left = tick_left - 1'b1;
          if (tick_left % 10'd50 == 0) begin
            r.display_refresh = 1'b1;
          end
        end
      end else begin
        oven_mode = MODE_CODE_ADJUST;
        r.display_refresh = 1'b1;
      end
    end else if (sw == SW_OFF) begin
      oven_mode = MODE_CODE_ADJUST;
      r.display_refresh = 1'b1;
    end
    prev_button = btn;
    if (oven_mode == MODE_CODE_HEATING) begin
      secs = tick_left / 10;
      if (secs > 7'd60) begin
        secs = 7'd60;
      end
      r.bar_count = secs / 5;
      r.heater_drive = timer_cfg.heater_active_level;
    end else begin
      r.heater_drive = ~timer_cfg.heater_active_level;
    end
    r.mode = oven_mode;
    r.minutes = set_minutes;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : score_results
    oven_result_t want;
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no tick pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("heater_drive", want.heater_drive, result_ch.heater_drive);
          check_field("mode", want.mode, result_ch.mode);
          check_field("minutes", want.minutes, result_ch.minutes);
          check_field("display_refresh", want.display_refresh, result_ch.display_refresh);
          check_field("bar_count", want.bar_count, result_ch.bar_count);
        end
      end
      if (tick_ch.valid && tick_ch.ready) begin
        expected_results.push_back(predict_tick(tick_ch.temperature, tick_ch.push_button,
                                                tick_ch.switch_state));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_tick(input logic [TEMP_W-1:0] temp, input logic [1:0] btn,
                           input logic [1:0] sw);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.temperature  <= temp;
    tick_ch.push_button  <= btn;
    tick_ch.switch_state <= sw;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic wait_drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data[CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_TEMP_LIMIT:       timer_cfg.temp_limit = data[TEMP_LIMIT_W-1:0];
      CFG_TICKS_PER_MINUTE: timer_cfg.ticks_per_minute = data[TICKS_W-1:0];
      CFG_MINUTE_WRAP:      timer_cfg.minute_wrap = data[MIN_W-1:0];
      CFG_LONG_PRESS_STEP:  timer_cfg.long_press_step = data[MIN_W-1:0];
      CFG_HEATER_LEVEL:     timer_cfg.heater_active_level = data[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned limit, input int unsigned tpm,
                                input int unsigned wrap, input int unsigned step,
                                input int unsigned level);
    wait_drain();
    write_reg(CFG_TEMP_LIMIT, limit);
    write_reg(CFG_TICKS_PER_MINUTE, tpm);
    write_reg(CFG_MINUTE_WRAP, wrap);
    write_reg(CFG_LONG_PRESS_STEP, step);
    write_reg(CFG_HEATER_LEVEL, level);
  endtask

  // mostly in range, sometimes over the limit, sometimes anything
  function automatic logic [TEMP_W-1:0] pick_temperature();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5 && timer_cfg.temp_limit < 12'hFFF) begin
      return $urandom_range(4095, timer_cfg.temp_limit + 1);
    end else if (pick < 10) begin
      return $urandom_range(4095);
    end
    return $urandom_range(timer_cfg.temp_limit);
  endfunction

  task automatic noise_tick();
    send_tick($urandom_range(4095), $urandom_range(3), $urandom_range(3));
  endtask

  task automatic cooking_cycle();
    int n;
    logic [1:0] b;
    n = $urandom_range(10, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0, 1: b = BTN_LONG;
        2:    b = 2'd3;
        default: b = (i % 2) ? BTN_PRESS : BTN_OFF;
      endcase
      send_tick(pick_temperature(), b, SW_OFF);
    end
    send_tick(pick_temperature(), BTN_OFF, SW_ON);
    n = $urandom_range(40, 1);
    for (int i = 0; i < n; i++) begin
      send_tick(pick_temperature(), $urandom_range(3), $urandom_range(3, 1));
    end
    n = $urandom_range(3, 1);
    for (int i = 0; i < n; i++) begin
      send_tick(pick_temperature(), $urandom_range(3), SW_OFF);
    end
  endtask

  task automatic random_phase(input int sender_pct, input int receiver_pct, input int count);
    int start;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start = ticks_sent;
    while (ticks_sent - start < count) begin
      if ($urandom_range(99) < 20) begin
        noise_tick();
      end else begin
        cooking_cycle();
      end
    end
  endtask

  task automatic test_adjust_keys();
    send_tick(12'd0, BTN_OFF, SW_OFF);
    send_tick(12'd200, BTN_PRESS, SW_OFF);
    send_tick(12'd200, BTN_PRESS, SW_OFF);
    send_tick(12'd0, 2'd3, 2'd3);
    send_tick(12'd0, BTN_PRESS, SW_OFF);
    repeat (8) send_tick(12'd0, BTN_LONG, SW_OFF);
    send_tick(12'd0, BTN_OFF, 2'd2);
    send_tick(12'd201, BTN_OFF, SW_OFF);
    send_tick(12'hFFF, BTN_LONG, 2'd3);
    send_tick(12'd0, BTN_OFF, SW_OFF);
  endtask

  task automatic test_countdown();
    apply_settings(200, 2, 120, 10, 0);
    send_tick(12'd4000, BTN_OFF, SW_OFF);
    send_tick(12'd0, BTN_OFF, SW_OFF);
    send_tick(12'd0, BTN_PRESS, SW_OFF);
    send_tick(12'd0, BTN_OFF, SW_ON);
    send_tick(12'd0, BTN_OFF, 2'd3);
    send_tick(12'd0, BTN_OFF, 2'd2);
    send_tick(12'd0, BTN_OFF, SW_ON);
    send_tick(12'd0, BTN_OFF, SW_OFF);
  endtask

  task automatic test_register_extremes();
    apply_settings(0, 0, 127, 127, 1);
    send_tick(12'd1, BTN_OFF, SW_OFF);
    send_tick(12'd0, BTN_OFF, SW_OFF);
    send_tick(12'd0, BTN_PRESS, SW_OFF);
    send_tick(12'd0, BTN_OFF, SW_ON);
    send_tick(12'd0, BTN_OFF, SW_ON);
    send_tick(12'd0, BTN_OFF, SW_OFF);
    apply_settings(4095, 1023, 127, 100, 0);
    repeat (8) send_tick(12'hFFF, BTN_LONG, SW_OFF);
    send_tick(12'hFFF, BTN_OFF, SW_ON);
    send_tick(12'hFFF, BTN_OFF, 2'd2);
    send_tick(12'd0, BTN_OFF, SW_OFF);
    wait_drain();
    write_reg(CFG_MINUTE_WRAP, 5);
    send_tick(12'd0, BTN_PRESS, SW_OFF);
    wait_drain();
    write_reg(CFG_MINUTE_WRAP, 1);
    send_tick(12'd0, BTN_OFF, SW_OFF);
    send_tick(12'd0, BTN_PRESS, SW_ON);
  endtask

  task automatic test_random_traffic();
    apply_settings(3000, 120, 127, 1, 0);
    random_phase(28, 56, 130);
    apply_settings($urandom_range(4094, 50), $urandom_range(60, 2), $urandom_range(126, 2),
                   $urandom_range(127, 1), 1);
    random_phase(56, 28, 130);
    apply_settings($urandom_range(4095), $urandom_range(200, 1), $urandom_range(127, 1),
                   $urandom_range(127, 1), $urandom_range(1));
    random_phase(0, 0, 130);
  endtask

  task automatic test_result_stall();
    wait_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 80;
    repeat (30) send_tick(pick_temperature(), $urandom_range(3), $urandom_range(3));
    wait_drain();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    tick_ch.valid = 1'b0;
    tick_ch.temperature = '0;
    tick_ch.push_button = BTN_OFF;
    tick_ch.switch_state = SW_OFF;
    result_ch.ready = 1'b0;
    fail_count = 0;
    ticks_sent = 0;
    cycle_count = 0;
    hold_off_left = 0;
    send_idle_pct = 28;
    recv_idle_pct = 56;
    timer_cfg.temp_limit = TEMP_LIMIT_RST;
    timer_cfg.ticks_per_minute = TICKS_PER_MINUTE_RST;
    timer_cfg.minute_wrap = MINUTE_WRAP_RST;
    timer_cfg.long_press_step = LONG_PRESS_STEP_RST;
    timer_cfg.heater_active_level = HEATER_LEVEL_RST;
    oven_mode = MODE_CODE_ADJUST;
    set_minutes = '0;
    tick_left = 10'd600;
    prev_button = BTN_OFF;
    hold_ticks = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_adjust_keys();
    test_countdown();
    test_register_extremes();
    test_random_traffic();
    test_result_stall();

    wait_drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
